@@ rtl/core/bbo_pkg.sv @@
`timescale 1ns / 1ps
package bbo_pkg;

    localparam int CW   = 16;             // bits per packed vector component
    localparam int AFB  = 14;             // fraction bits of an axis component
    localparam int FW   = 48;             // width of one packed input field
    localparam int NFLD = 10;
    localparam int NAX  = 15;             // candidate axes
    localparam int NCR  = 9;              // cross-product axes

    localparam int DW   = CW + 1;         // centre difference
    localparam int XW   = 2 * CW;         // one cross-product partial term
    localparam int LW   = 2 * CW + 1;     // candidate axis component
    localparam int DPW  = DW + LW;
    localparam int DSW  = DPW + 2;        // centre distance along an axis
    localparam int APW  = LW + CW;
    localparam int ASW  = APW + 2;        // axis against box axis
    localparam int SQW  = 2 * LW;
    localparam int SQSW = SQW + 2;        // squared axis length
    localparam int HLO  = (ASW + 1) / 2;  // split of the extent multiply
    localparam int HHI  = ASW - HLO;
    localparam int TW   = ASW + CW;
    localparam int BW   = TW + 2;         // projected extent of one box
    localparam int PW   = BW + 1;
    localparam int CMPW = (PW > DSW + AFB) ? PW : DSW + AFB;

    localparam int SIW  = 8;              // result bus width
    localparam logic [3:0] NO_SEP = 4'd15;

    // Cross axes with len2 * 10000 < 2^(4*AFB) are skipped.
    localparam longint unsigned SKIP_LEN2 =
        ((64'd1 << (4 * AFB)) + 64'd9999) / 64'd10000;

    typedef logic signed [CW-1:0] comp_t;

endpackage

@@ rtl/core/box_box_overlap_test_core.sv @@
`timescale 1ns / 1ps
// An accepted request passes through the stages of the plan below before its result reaches the m_ side.
// Throughput: one box pair per cycle while m_tready keeps up; every stage holds its own valid
// bit, so a stalled output only holds the stages that are full behind it.
// Reset: aresetn is synchronous and active low; it clears all valid bits, and the
// data registers keep whatever they held.
module box_box_overlap_test_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up, 48 bits each: a_centre, a_axis_x, a_axis_y, a_axis_z,
    // a_half_size, b_centre, b_axis_x, b_axis_y, b_axis_z, b_half_size.
    input  logic [bbo_pkg::NFLD*bbo_pkg::FW-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: overlap (1 bit), separating_axis (4 bits), zero fill.
    output logic [bbo_pkg::SIW-1:0]       m_tdata
);

    // Stage plan:
    //   1: unpack, centre difference, the six products of each cross axis
    //   2: candidate axes (cross products completed, face axes widened)
    //   3: every product of the candidate with d, with the six box axes, with itself
    //   4: the dot-product sums, their magnitudes and the near-parallel skip flag
    //   5: magnitudes times half extents, cut into two narrow multiplies
    //   6: projected extent of each box
    //   7: per-axis separation flag
    //   8: output register holding the first separating axis
    // Each stage loads when it is empty or the stage after it moves.

    localparam int NST = 7;

    logic [NST:0] vld;
    logic [NST:1] en;
    logic         en_out;
    logic [NST:1] vld_reg;

    assign vld[0]     = s_tvalid;
    assign vld[NST:1] = vld_reg;
    assign en_out     = !m_tvalid || m_tready;

    always_comb begin
        en[NST] = !vld_reg[NST] || en_out;
        for (int s = NST - 1; s >= 1; s--) begin
            en[s] = !vld_reg[s] || en[s + 1];
        end
    end

    assign s_tready = en[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int s = 1; s <= NST; s++) begin
                if (en[s]) begin
                    vld_reg[s] <= vld[s - 1];
                end
            end
        end
    end

    // ---------------- stage 1 ----------------
    bbo_pkg::comp_t                     ax1_reg [6][3];
    bbo_pkg::comp_t                     ax1_next[6][3];
    logic [bbo_pkg::CW-1:0]             h1_reg  [2][3];
    logic [bbo_pkg::CW-1:0]             h1_next [2][3];
    logic signed [bbo_pkg::DW-1:0]      d1_reg  [3];
    logic signed [bbo_pkg::DW-1:0]      d1_next [3];
    logic signed [bbo_pkg::XW-1:0]      xp1_reg [bbo_pkg::NCR][6];
    logic signed [bbo_pkg::XW-1:0]      xp1_next[bbo_pkg::NCR][6];

    always_comb begin
        bbo_pkg::comp_t ca [3];
        bbo_pkg::comp_t cb [3];
        for (int k = 0; k < 3; k++) begin
            ca[k] = s_tdata[0 * bbo_pkg::FW + k * bbo_pkg::CW +: bbo_pkg::CW];
            cb[k] = s_tdata[5 * bbo_pkg::FW + k * bbo_pkg::CW +: bbo_pkg::CW];
            d1_next[k] = bbo_pkg::DW'(cb[k]) - bbo_pkg::DW'(ca[k]);
            h1_next[0][k] = s_tdata[4 * bbo_pkg::FW + k * bbo_pkg::CW +: bbo_pkg::CW];
            h1_next[1][k] = s_tdata[9 * bbo_pkg::FW + k * bbo_pkg::CW +: bbo_pkg::CW];
            for (int m = 0; m < 3; m++) begin
                ax1_next[m][k] =
                    s_tdata[(1 + m) * bbo_pkg::FW + k * bbo_pkg::CW +: bbo_pkg::CW];
                ax1_next[3 + m][k] =
                    s_tdata[(6 + m) * bbo_pkg::FW + k * bbo_pkg::CW +: bbo_pkg::CW];
            end
        end
        // Cross axis c = A_i x B_j with i = c / 3, j = c % 3.
        for (int c = 0; c < bbo_pkg::NCR; c++) begin
            xp1_next[c][0] = ax1_next[c / 3][1] * ax1_next[3 + c % 3][2];
            xp1_next[c][1] = ax1_next[c / 3][2] * ax1_next[3 + c % 3][1];
            xp1_next[c][2] = ax1_next[c / 3][2] * ax1_next[3 + c % 3][0];
            xp1_next[c][3] = ax1_next[c / 3][0] * ax1_next[3 + c % 3][2];
            xp1_next[c][4] = ax1_next[c / 3][0] * ax1_next[3 + c % 3][1];
            xp1_next[c][5] = ax1_next[c / 3][1] * ax1_next[3 + c % 3][0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            ax1_reg <= ax1_next;
            h1_reg  <= h1_next;
            d1_reg  <= d1_next;
            xp1_reg <= xp1_next;
        end
    end

    // ---------------- stage 2 ----------------
    bbo_pkg::comp_t                     ax2_reg  [6][3];
    logic [bbo_pkg::CW-1:0]             h2_reg   [2][3];
    logic signed [bbo_pkg::DW-1:0]      d2_reg   [3];
    logic signed [bbo_pkg::LW-1:0]      cand2_reg [bbo_pkg::NAX][3];
    logic signed [bbo_pkg::LW-1:0]      cand2_next[bbo_pkg::NAX][3];

    always_comb begin
        for (int m = 0; m < 6; m++) begin
            for (int k = 0; k < 3; k++) begin
                cand2_next[m][k] = bbo_pkg::LW'(ax1_reg[m][k]);
            end
        end
        for (int c = 0; c < bbo_pkg::NCR; c++) begin
            for (int k = 0; k < 3; k++) begin
                cand2_next[6 + c][k] = bbo_pkg::LW'(xp1_reg[c][2 * k])
                                     - bbo_pkg::LW'(xp1_reg[c][2 * k + 1]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            ax2_reg   <= ax1_reg;
            h2_reg    <= h1_reg;
            d2_reg    <= d1_reg;
            cand2_reg <= cand2_next;
        end
    end

    // ---------------- stage 3 ----------------
    logic [bbo_pkg::CW-1:0]             h3_reg  [2][3];
    logic signed [bbo_pkg::DPW-1:0]     pd3_reg [bbo_pkg::NAX][3];
    logic signed [bbo_pkg::DPW-1:0]     pd3_next[bbo_pkg::NAX][3];
    logic signed [bbo_pkg::APW-1:0]     pa3_reg [bbo_pkg::NAX][6][3];
    logic signed [bbo_pkg::APW-1:0]     pa3_next[bbo_pkg::NAX][6][3];
    logic signed [bbo_pkg::SQW-1:0]     sq3_reg [bbo_pkg::NAX][3];
    logic signed [bbo_pkg::SQW-1:0]     sq3_next[bbo_pkg::NAX][3];

    always_comb begin
        for (int c = 0; c < bbo_pkg::NAX; c++) begin
            for (int k = 0; k < 3; k++) begin
                pd3_next[c][k] = bbo_pkg::DPW'(d2_reg[k]) * bbo_pkg::DPW'(cand2_reg[c][k]);
                sq3_next[c][k] = bbo_pkg::SQW'(cand2_reg[c][k])
                               * bbo_pkg::SQW'(cand2_reg[c][k]);
                for (int m = 0; m < 6; m++) begin
                    pa3_next[c][m][k] = bbo_pkg::APW'(cand2_reg[c][k])
                                      * bbo_pkg::APW'(ax2_reg[m][k]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            h3_reg  <= h2_reg;
            pd3_reg <= pd3_next;
            pa3_reg <= pa3_next;
            sq3_reg <= sq3_next;
        end
    end

    // ---------------- stage 4 ----------------
    logic [bbo_pkg::CW-1:0]             h4_reg   [2][3];
    logic [bbo_pkg::DSW-1:0]            dabs4_reg [bbo_pkg::NAX];
    logic [bbo_pkg::DSW-1:0]            dabs4_next[bbo_pkg::NAX];
    logic [bbo_pkg::ASW-1:0]            aabs4_reg [bbo_pkg::NAX][6];
    logic [bbo_pkg::ASW-1:0]            aabs4_next[bbo_pkg::NAX][6];
    logic [bbo_pkg::NAX-1:0]            skip4_reg;
    logic [bbo_pkg::NAX-1:0]            skip4_next;

    always_comb begin
        logic signed [bbo_pkg::DSW-1:0]  ds;
        logic signed [bbo_pkg::ASW-1:0]  as;
        logic signed [bbo_pkg::SQSW-1:0] len2;
        for (int c = 0; c < bbo_pkg::NAX; c++) begin
            ds = bbo_pkg::DSW'(pd3_reg[c][0]) + bbo_pkg::DSW'(pd3_reg[c][1])
               + bbo_pkg::DSW'(pd3_reg[c][2]);
            dabs4_next[c] = ds[bbo_pkg::DSW-1] ? -ds : ds;
            for (int m = 0; m < 6; m++) begin
                as = bbo_pkg::ASW'(pa3_reg[c][m][0]) + bbo_pkg::ASW'(pa3_reg[c][m][1])
                   + bbo_pkg::ASW'(pa3_reg[c][m][2]);
                aabs4_next[c][m] = as[bbo_pkg::ASW-1] ? -as : as;
            end
            len2 = bbo_pkg::SQSW'(sq3_reg[c][0]) + bbo_pkg::SQSW'(sq3_reg[c][1])
                 + bbo_pkg::SQSW'(sq3_reg[c][2]);
            // Face axes are never skipped, only near-parallel edge pairs.
            skip4_next[c] = (c >= 6) &&
                            (len2 < bbo_pkg::SQSW'(bbo_pkg::SKIP_LEN2));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            h4_reg    <= h3_reg;
            dabs4_reg <= dabs4_next;
            aabs4_reg <= aabs4_next;
            skip4_reg <= skip4_next;
        end
    end

    // ---------------- stage 5 ----------------
    logic [bbo_pkg::DSW-1:0]            dabs5_reg[bbo_pkg::NAX];
    logic [bbo_pkg::NAX-1:0]            skip5_reg;
    logic [bbo_pkg::HLO+bbo_pkg::CW-1:0] hl5_reg [bbo_pkg::NAX][6];
    logic [bbo_pkg::HLO+bbo_pkg::CW-1:0] hl5_next[bbo_pkg::NAX][6];
    logic [bbo_pkg::HHI+bbo_pkg::CW-1:0] hh5_reg [bbo_pkg::NAX][6];
    logic [bbo_pkg::HHI+bbo_pkg::CW-1:0] hh5_next[bbo_pkg::NAX][6];

    always_comb begin
        for (int c = 0; c < bbo_pkg::NAX; c++) begin
            for (int m = 0; m < 6; m++) begin
                hl5_next[c][m] = (bbo_pkg::HLO + bbo_pkg::CW)'(
                                     aabs4_reg[c][m][bbo_pkg::HLO-1:0])
                               * (bbo_pkg::HLO + bbo_pkg::CW)'(h4_reg[m / 3][m % 3]);
                hh5_next[c][m] = (bbo_pkg::HHI + bbo_pkg::CW)'(
                                     aabs4_reg[c][m][bbo_pkg::ASW-1:bbo_pkg::HLO])
                               * (bbo_pkg::HHI + bbo_pkg::CW)'(h4_reg[m / 3][m % 3]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            dabs5_reg <= dabs4_reg;
            skip5_reg <= skip4_reg;
            hl5_reg   <= hl5_next;
            hh5_reg   <= hh5_next;
        end
    end

    // ---------------- stage 6 ----------------
    logic [bbo_pkg::DSW-1:0]            dabs6_reg[bbo_pkg::NAX];
    logic [bbo_pkg::NAX-1:0]            skip6_reg;
    logic [bbo_pkg::BW-1:0]             bs6_reg [bbo_pkg::NAX][2];
    logic [bbo_pkg::BW-1:0]             bs6_next[bbo_pkg::NAX][2];

    always_comb begin
        logic [bbo_pkg::TW-1:0] term;
        for (int c = 0; c < bbo_pkg::NAX; c++) begin
            for (int b = 0; b < 2; b++) begin
                bs6_next[c][b] = '0;
                for (int k = 0; k < 3; k++) begin
                    term = bbo_pkg::TW'(hl5_reg[c][3 * b + k])
                         + (bbo_pkg::TW'(hh5_reg[c][3 * b + k]) << bbo_pkg::HLO);
                    bs6_next[c][b] = bs6_next[c][b] + bbo_pkg::BW'(term);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            dabs6_reg <= dabs5_reg;
            skip6_reg <= skip5_reg;
            bs6_reg   <= bs6_next;
        end
    end

    // ---------------- stage 7 ----------------
    // An axis separates when the centre distance reaches the summed extents;
    // touching counts as apart.
    logic [bbo_pkg::NAX-1:0]            sep7_reg;
    logic [bbo_pkg::NAX-1:0]            sep7_next;

    always_comb begin
        logic [bbo_pkg::CMPW-1:0] cdist;
        logic [bbo_pkg::CMPW-1:0] proj;
        for (int c = 0; c < bbo_pkg::NAX; c++) begin
            cdist = bbo_pkg::CMPW'(dabs6_reg[c]) << bbo_pkg::AFB;
            proj = bbo_pkg::CMPW'(bs6_reg[c][0]) + bbo_pkg::CMPW'(bs6_reg[c][1]);
            sep7_next[c] = !skip6_reg[c] && !(cdist < proj);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            sep7_reg <= sep7_next;
        end
    end

    // ---------------- output register ----------------
    logic                     m_valid_reg;
    logic [3:0]               sep_axis_reg;
    logic [3:0]               sep_axis_next;

    always_comb begin
        sep_axis_next = bbo_pkg::NO_SEP;
        for (int c = bbo_pkg::NAX - 1; c >= 0; c--) begin
            if (sep7_reg[c]) begin
                sep_axis_next = 4'(c);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= vld[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            sep_axis_reg <= sep_axis_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, sep_axis_reg, sep_axis_reg == bbo_pkg::NO_SEP};

endmodule

@@ rtl/core/bbo_checker.sv @@
`timescale 1ns / 1ps
module bbo_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bbo_pkg::NFLD*bbo_pkg::FW-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bbo_pkg::SIW-1:0]       m_tdata
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The overlap flag agrees with the axis index.
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == bbo_pkg::NO_SEP)))
        else $error("overlap flag and axis index disagree");

    // The fill bits stay zero.
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:5] == 3'b000)
        else $error("fill bits set");

    // Reset empties the pipeline.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A result cannot appear before a request has gone through.
    a_src: assert property (@(posedge aclk)
        !aresetn ##1 !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result without a request");

endmodule

bind box_box_overlap_test_core bbo_checker u_bbo_checker (.*);
